@@ sv/circle_tile_grid_collision_core_defines.svh @@
// assertion macros for the circle tile grid collision core
`ifndef CIRCLE_TILE_GRID_COLLISION_CORE_DEFINES_SVH
`define CIRCLE_TILE_GRID_COLLISION_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CTG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ctg assertion failed: same-cycle check");

// next-cycle implication, disabled during reset
`define CTG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ctg assertion failed: next-cycle check");

`endif

@@ sv/ctg_pkg.sv @@
// types and constants shared by the circle tile grid collision core
`timescale 1ns / 1ps

package ctg_pkg;

	localparam int POS_W  = 24;
	localparam int RAD_W  = 16;
	localparam int TS_W   = 16;
	localparam int DIM_W  = 23;
	localparam int EXT_W  = 26;
	localparam int IDX_W  = 7;
	localparam int QUO_W  = 7;
	localparam int BIT_W  = 3;
	localparam int PROD_W = 32;
	localparam int CFG_W  = 2;
	localparam int DATA_W = 16;

	localparam logic [7:0] CODE_WALL  = 8'h26;
	localparam logic [7:0] CODE_GREEN = 8'h40;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic [CFG_W-1:0] CFG_TILE_SIZE   = 2'd0;
	localparam logic [CFG_W-1:0] CFG_MAP_COLUMNS = 2'd1;
	localparam logic [CFG_W-1:0] CFG_MAP_ROWS    = 2'd2;

	localparam logic [TS_W-1:0]  TILE_SIZE_RST   = 16'd256;
	localparam logic [IDX_W-1:0] MAP_COLUMNS_RST = 7'd64;
	localparam logic [IDX_W-1:0] MAP_ROWS_RST    = 7'd64;

	typedef logic signed [EXT_W-1:0] ext_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL_W,
		ST_MUL_H,
		ST_MUL_R,
		ST_BOUND,
		ST_DIV,
		ST_TILE,
		ST_READ,
		ST_SQX,
		ST_SQZ,
		ST_CMP,
		ST_ADV,
		ST_DONE
	} state_t;

endpackage

@@ sv/circle_tile_grid_collision_core.sv @@
// top level of the circle tile grid collision core
`timescale 1ns / 1ps
`include "circle_tile_grid_collision_core_defines.svh"

// Circle against tile grid collision test with a one-bit solid map of
// MAX_ROWS x MAX_COLUMNS tiles held in a single-port-write, single-port-read
// memory. After reset a clearing pass writes every map entry to zero, one per
// cycle; items are not taken meanwhile, configuration writes are. A tile write
// leaves the core idle, so writes can come back to back. A query runs through
// one shared 16x16 multiplier and one shared compare-subtract unit: first the
// map size, radius squared and boundary test (a boundary hit or zero tile size
// ends there), then the four 7-step restoring divisions that find the covered
// tile range, then per covered tile a map range check and advance if it lies
// off the map, also a map read if it is empty, also both squared distances and
// a compare if it is solid, ending early on a tile hit. The result register
// is loaded once it is empty or its result is being taken, and it lets the
// next item be accepted while the previous result still waits.
module circle_tile_grid_collision_core #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              action,
	input  logic [5:0]                        tile_col,
	input  logic [5:0]                        tile_row,
	input  logic [7:0]                        tile_code,
	input  logic signed [ctg_pkg::POS_W-1:0]  pos_x,
	input  logic signed [ctg_pkg::POS_W-1:0]  pos_z,
	input  logic [ctg_pkg::RAD_W-1:0]         radius,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              collided,
	output logic                              hit_boundary,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ctg_pkg::CFG_W-1:0]         cfg_index,
	input  logic [ctg_pkg::DATA_W-1:0]        cfg_data
);

	localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	ctg_pkg::state_t state_q, state_d;

	logic [ctg_pkg::TS_W-1:0]   tile_size_q;
	logic [ctg_pkg::IDX_W-1:0]  map_columns_q;
	logic [ctg_pkg::IDX_W-1:0]  map_rows_q;

	logic [AW-1:0]              clr_addr_q;
	logic                       solid_mem_q [DEPTH];
	logic                       rd_solid_q;

	logic                       out_valid_q;
	logic                       collided_q;
	logic                       hit_boundary_q;
	logic                       res_hit_q;
	logic                       res_bnd_q;

	ctg_pkg::ext_t              x_q, z_q;
	ctg_pkg::ext_t              lo_x_q, hi_x_q, lo_z_q, hi_z_q;
	logic [ctg_pkg::RAD_W-1:0]  r_q;
	logic [ctg_pkg::DIM_W-1:0]  w_q, h_q;
	logic [ctg_pkg::PROD_W-1:0] r2_q, sqx_q, sqz_q;

	logic [ctg_pkg::EXT_W-1:0]  rem_q;
	logic [ctg_pkg::QUO_W-1:0]  quo_q;
	logic [ctg_pkg::BIT_W-1:0]  div_bit_q;
	logic [1:0]                 div_sel_q;

	logic [ctg_pkg::IDX_W-1:0]  min_col_q, max_col_q, min_row_q, max_row_q;
	logic [ctg_pkg::IDX_W-1:0]  col_q, row_q;
	ctg_pkg::ext_t              left0_q, top0_q, left_q, top_q;
	logic [ctg_pkg::RAD_W-1:0]  ax_q, az_q;

	logic                       in_fire;
	logic                       out_load;
	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	logic                       mem_wdata;
	logic                       wr_in_range;
	logic [AW-1:0]              scan_addr;
	logic                       tile_in_map;
	logic                       bound_hit;
	logic                       sq_hit;
	logic                       div_last;
	logic                       div_ge;
	logic [ctg_pkg::EXT_W-1:0]  div_shift;
	logic [ctg_pkg::EXT_W-1:0]  div_rem_d;
	logic [ctg_pkg::QUO_W-1:0]  div_quo_d;
	logic [ctg_pkg::EXT_W-1:0]  div_next_src;
	ctg_pkg::ext_t              ts_ext, x_ext, z_ext, r_ext;
	ctg_pkg::ext_t              right_x, bottom_z, dx_full, dz_full;
	logic [ctg_pkg::RAD_W-1:0]  mul_a, mul_b;
	logic [ctg_pkg::PROD_W-1:0] mul_p;
	logic [ctg_pkg::PROD_W:0]   sq_sum;

	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign collided     = collided_q;
	assign hit_boundary = hit_boundary_q;

	assign in_fire  = in_valid && in_ready;
	assign out_load = (state_q == ctg_pkg::ST_DONE) && (!out_valid_q || out_ready);

	assign ts_ext = ctg_pkg::ext_t'(tile_size_q);
	assign x_ext  = ctg_pkg::ext_t'(pos_x);
	assign z_ext  = ctg_pkg::ext_t'(pos_z);
	assign r_ext  = ctg_pkg::ext_t'(radius);

	// map write port: clearing pass or tile write
	assign wr_in_range = (int'(tile_col) < MAX_COLUMNS) && (int'(tile_row) < MAX_ROWS);
	always_comb begin
		if (state_q == ctg_pkg::ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = 1'b0;
		end else begin
			mem_we    = in_fire && (action == ctg_pkg::ACT_WRITE) && wr_in_range;
			mem_waddr = AW'(int'(tile_row) * MAX_COLUMNS + int'(tile_col));
			mem_wdata = (tile_code == ctg_pkg::CODE_WALL) || (tile_code == ctg_pkg::CODE_GREEN);
		end
	end

	assign scan_addr   = AW'(int'(row_q) * MAX_COLUMNS + int'(col_q));
	assign tile_in_map = (col_q < map_columns_q) && (int'(col_q) < MAX_COLUMNS)
		&& (row_q < map_rows_q) && (int'(row_q) < MAX_ROWS);

	assign bound_hit = (lo_x_q < 0) || (hi_x_q > ctg_pkg::ext_t'(w_q))
		|| (lo_z_q < 0) || (hi_z_q > ctg_pkg::ext_t'(h_q));

	// shared restoring divide step
	assign div_shift = ctg_pkg::EXT_W'(tile_size_q) << div_bit_q;
	assign div_ge    = rem_q >= div_shift;
	assign div_rem_d = div_ge ? (rem_q - div_shift) : rem_q;
	assign div_quo_d = {quo_q[ctg_pkg::QUO_W-2:0], div_ge};
	assign div_last  = (div_bit_q == '0);

	always_comb begin
		case (div_sel_q)
			2'd0:    div_next_src = hi_x_q;
			2'd1:    div_next_src = lo_z_q;
			default: div_next_src = hi_z_q;
		endcase
	end

	// clamp distances
	assign right_x  = left_q + ts_ext;
	assign bottom_z = top_q + ts_ext;
	always_comb begin
		if (x_q < left_q) begin
			dx_full = left_q - x_q;
		end else if (x_q > right_x) begin
			dx_full = x_q - right_x;
		end else begin
			dx_full = '0;
		end
		if (z_q < top_q) begin
			dz_full = top_q - z_q;
		end else if (z_q > bottom_z) begin
			dz_full = z_q - bottom_z;
		end else begin
			dz_full = '0;
		end
	end

	// shared multiplier
	always_comb begin
		unique case (state_q)
			ctg_pkg::ST_MUL_W: begin
				mul_a = ctg_pkg::RAD_W'(map_columns_q);
				mul_b = tile_size_q;
			end
			ctg_pkg::ST_MUL_H: begin
				mul_a = ctg_pkg::RAD_W'(map_rows_q);
				mul_b = tile_size_q;
			end
			ctg_pkg::ST_MUL_R: begin
				mul_a = r_q;
				mul_b = r_q;
			end
			ctg_pkg::ST_SQX: begin
				mul_a = ax_q;
				mul_b = ax_q;
			end
			default: begin
				mul_a = az_q;
				mul_b = az_q;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	assign sq_sum = {1'b0, sqx_q} + {1'b0, sqz_q};
	assign sq_hit = sq_sum < {1'b0, r2_q};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctg_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ctg_pkg::ST_CLEAR: begin
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					state_d = ctg_pkg::ST_IDLE;
				end
			end
			ctg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && (action == ctg_pkg::ACT_QUERY)) begin
					state_d = ctg_pkg::ST_MUL_W;
				end
			end
			ctg_pkg::ST_MUL_W: state_d = ctg_pkg::ST_MUL_H;
			ctg_pkg::ST_MUL_H: state_d = ctg_pkg::ST_MUL_R;
			ctg_pkg::ST_MUL_R: state_d = ctg_pkg::ST_BOUND;
			ctg_pkg::ST_BOUND: begin
				if (bound_hit || (tile_size_q == '0)) begin
					state_d = ctg_pkg::ST_DONE;
				end else begin
					state_d = ctg_pkg::ST_DIV;
				end
			end
			ctg_pkg::ST_DIV: begin
				if (div_last && (div_sel_q == 2'd3)) begin
					state_d = ctg_pkg::ST_TILE;
				end
			end
			ctg_pkg::ST_TILE: begin
				state_d = tile_in_map ? ctg_pkg::ST_READ : ctg_pkg::ST_ADV;
			end
			ctg_pkg::ST_READ: begin
				state_d = rd_solid_q ? ctg_pkg::ST_SQX : ctg_pkg::ST_ADV;
			end
			ctg_pkg::ST_SQX: state_d = ctg_pkg::ST_SQZ;
			ctg_pkg::ST_SQZ: state_d = ctg_pkg::ST_CMP;
			ctg_pkg::ST_CMP: begin
				state_d = sq_hit ? ctg_pkg::ST_DONE : ctg_pkg::ST_ADV;
			end
			ctg_pkg::ST_ADV: begin
				if ((col_q == max_col_q) && (row_q == max_row_q)) begin
					state_d = ctg_pkg::ST_DONE;
				end else begin
					state_d = ctg_pkg::ST_TILE;
				end
			end
			ctg_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = ctg_pkg::ST_IDLE;
				end
			end
			default: state_d = ctg_pkg::ST_CLEAR;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q    <= '0;
			out_valid_q   <= 1'b0;
			tile_size_q   <= ctg_pkg::TILE_SIZE_RST;
			map_columns_q <= ctg_pkg::MAP_COLUMNS_RST;
			map_rows_q    <= ctg_pkg::MAP_ROWS_RST;
		end else begin
			if (state_q == ctg_pkg::ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					ctg_pkg::CFG_TILE_SIZE:   tile_size_q   <= cfg_data;
					ctg_pkg::CFG_MAP_COLUMNS: map_columns_q <= cfg_data[ctg_pkg::IDX_W-1:0];
					ctg_pkg::CFG_MAP_ROWS:    map_rows_q    <= cfg_data[ctg_pkg::IDX_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// solid map
	always_ff @(posedge clk) begin
		if (mem_we) begin
			solid_mem_q[mem_waddr] <= mem_wdata;
		end
		if (state_q == ctg_pkg::ST_TILE) begin
			rd_solid_q <= solid_mem_q[scan_addr];
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (out_load) begin
			collided_q     <= res_hit_q;
			hit_boundary_q <= res_bnd_q;
		end
		unique case (state_q)
			ctg_pkg::ST_IDLE: begin
				if (in_fire) begin
					x_q    <= x_ext;
					z_q    <= z_ext;
					r_q    <= radius;
					lo_x_q <= x_ext - r_ext;
					hi_x_q <= x_ext + r_ext;
					lo_z_q <= z_ext - r_ext;
					hi_z_q <= z_ext + r_ext;
				end
			end
			ctg_pkg::ST_MUL_W: w_q  <= mul_p[ctg_pkg::DIM_W-1:0];
			ctg_pkg::ST_MUL_H: h_q  <= mul_p[ctg_pkg::DIM_W-1:0];
			ctg_pkg::ST_MUL_R: r2_q <= mul_p;
			ctg_pkg::ST_BOUND: begin
				res_hit_q <= bound_hit;
				res_bnd_q <= bound_hit;
				rem_q     <= lo_x_q;
				quo_q     <= '0;
				div_bit_q <= ctg_pkg::BIT_W'(ctg_pkg::QUO_W - 1);
				div_sel_q <= 2'd0;
			end
			ctg_pkg::ST_DIV: begin
				if (!div_last) begin
					rem_q     <= div_rem_d;
					quo_q     <= div_quo_d;
					div_bit_q <= div_bit_q - 1'b1;
				end else begin
					case (div_sel_q)
						2'd0: begin
							min_col_q <= div_quo_d;
							left0_q   <= lo_x_q - ctg_pkg::ext_t'(div_rem_d);
						end
						2'd1: max_col_q <= div_quo_d;
						2'd2: begin
							min_row_q <= div_quo_d;
							top0_q    <= lo_z_q - ctg_pkg::ext_t'(div_rem_d);
						end
						default: begin
							max_row_q <= div_quo_d;
							col_q     <= min_col_q;
							row_q     <= min_row_q;
							left_q    <= left0_q;
							top_q     <= top0_q;
						end
					endcase
					rem_q     <= div_next_src;
					quo_q     <= '0;
					div_bit_q <= ctg_pkg::BIT_W'(ctg_pkg::QUO_W - 1);
					div_sel_q <= div_sel_q + 1'b1;
				end
			end
			ctg_pkg::ST_READ: begin
				ax_q <= dx_full[ctg_pkg::RAD_W-1:0];
				az_q <= dz_full[ctg_pkg::RAD_W-1:0];
			end
			ctg_pkg::ST_SQX: sqx_q <= mul_p;
			ctg_pkg::ST_SQZ: sqz_q <= mul_p;
			ctg_pkg::ST_CMP: begin
				if (sq_hit) begin
					res_hit_q <= 1'b1;
				end
			end
			ctg_pkg::ST_ADV: begin
				if (col_q == max_col_q) begin
					col_q  <= min_col_q;
					left_q <= left0_q;
					row_q  <= row_q + 1'b1;
					top_q  <= top_q + ts_ext;
				end else begin
					col_q  <= col_q + 1'b1;
					left_q <= left_q + ts_ext;
				end
			end
			default: ;
		endcase
	end

	`CTG_ASSERT_NEXT(a_query_busy, clk, arst_n, in_fire && (action == ctg_pkg::ACT_QUERY), !in_ready)
	`CTG_ASSERT_NOW(a_bound_is_hit, clk, arst_n, (state_q == ctg_pkg::ST_DONE) && res_bnd_q, res_hit_q)
	`CTG_ASSERT_NOW(a_read_in_map, clk, arst_n, state_q == ctg_pkg::ST_READ, (col_q < map_columns_q) && (row_q < map_rows_q))
	`CTG_ASSERT_NOW(a_out_flags, clk, arst_n, out_valid_q, collided_q || !hit_boundary_q)

endmodule

@@ verif/circle_tile_grid_collision_core_tb.sv @@
// testbench for the circle tile grid collision core: tile map writes and circle queries
`timescale 1ns / 1ps

module circle_tile_grid_collision_core_tb;

	localparam int GRID_COLS      = 64;
	localparam int GRID_ROWS      = 64;
	localparam int IDLE_PCT       = 36;
	localparam int SETTLE_CYCLES  = 16;
	localparam int WATCHDOG_LIMIT = 100000;
	localparam int HOLD_CYCLES    = 500;
	localparam logic [ctg_pkg::CFG_W-1:0] CFG_SPARE = 2'd3;

	typedef struct {
		logic                             action;
		logic [5:0]                       tile_col;
		logic [5:0]                       tile_row;
		logic [7:0]                       tile_code;
		logic signed [ctg_pkg::POS_W-1:0] pos_x;
		logic signed [ctg_pkg::POS_W-1:0] pos_z;
		logic [ctg_pkg::RAD_W-1:0]        radius;
	} grid_item_t;

	typedef struct packed {
		logic collided;
		logic hit_boundary;
	} result_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_ready;
	logic                             action = ctg_pkg::ACT_WRITE;
	logic [5:0]                       tile_col = '0;
	logic [5:0]                       tile_row = '0;
	logic [7:0]                       tile_code = '0;
	logic signed [ctg_pkg::POS_W-1:0] pos_x = '0;
	logic signed [ctg_pkg::POS_W-1:0] pos_z = '0;
	logic [ctg_pkg::RAD_W-1:0]        radius = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic                             collided;
	logic                             hit_boundary;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [ctg_pkg::CFG_W-1:0]        cfg_index = '0;
	logic [ctg_pkg::DATA_W-1:0]       cfg_data = '0;

	bit solid_tiles [GRID_ROWS][GRID_COLS];
	logic [ctg_pkg::TS_W-1:0]  tile_size_q = ctg_pkg::TILE_SIZE_RST;
	logic [ctg_pkg::IDX_W-1:0] map_cols_q  = ctg_pkg::MAP_COLUMNS_RST;
	logic [ctg_pkg::IDX_W-1:0] map_rows_q  = ctg_pkg::MAP_ROWS_RST;
	int last_col = 0;
	int last_row = 0;

	result_t pending_results [$];
	bit steady_flow = 1'b0;
	int hold_request = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	int errors = 0;
	int n_tile_writes = 0;
	int n_queries = 0;
	int n_boundary_hits = 0;
	int n_tile_hits = 0;
	int n_misses = 0;
	int n_reg_writes = 0;
	int n_settings = 0;

	circle_tile_grid_collision_core #(
		.MAX_COLUMNS(GRID_COLS),
		.MAX_ROWS(GRID_ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.tile_col(tile_col),
		.tile_row(tile_row),
		.tile_code(tile_code),
		.pos_x(pos_x),
		.pos_z(pos_z),
		.radius(radius),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.collided(collided),
		.hit_boundary(hit_boundary),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic result_t collision_for(input logic signed [ctg_pkg::POS_W-1:0] px,
		input logic signed [ctg_pkg::POS_W-1:0] pz, input logic [ctg_pkg::RAD_W-1:0] rad);
		result_t res;
		longint x, z, r, ts, cols, rows, w, h, row, col, left, top, dx, dz;
		res = '0;
		x = longint'(px);
		z = longint'(pz);
		r = longint'(rad);
		ts = longint'(tile_size_q);
		cols = longint'(map_cols_q);
		rows = longint'(map_rows_q);
		w = cols * ts;
		h = rows * ts;
		if (x - r < 0 || x + r > w || z - r < 0 || z + r > h) begin
			res.collided = 1'b1;
			res.hit_boundary = 1'b1;
			return res;
		end
		if (ts == 0)
			return res;
		for (row = (z - r) / ts; row <= (z + r) / ts; row++) begin
			for (col = (x - r) / ts; col <= (x + r) / ts; col++) begin
				if (col < cols && col < GRID_COLS && row < rows && row < GRID_ROWS &&
					solid_tiles[row][col]) begin
					left = col * ts;
					top = row * ts;
					dx = (x < left) ? left - x : (x > left + ts) ? x - left - ts : 0;
					dz = (z < top) ? top - z : (z > top + ts) ? z - top - ts : 0;
					if (dx * dx + dz * dz < r * r) begin
						res.collided = 1'b1;
						return res;
					end
				end
			end
		end
		return res;
	endfunction

	function automatic grid_item_t tile_item(input int col, input int row,
		input logic [7:0] code);
		grid_item_t it;
		it = '{default: '0};
		it.action = ctg_pkg::ACT_WRITE;
		it.tile_col = col[5:0];
		it.tile_row = row[5:0];
		it.tile_code = code;
		return it;
	endfunction

	function automatic grid_item_t query_item(input longint x, input longint z,
		input longint r);
		grid_item_t it;
		it = '{default: '0};
		it.action = ctg_pkg::ACT_QUERY;
		it.pos_x = x[ctg_pkg::POS_W-1:0];
		it.pos_z = z[ctg_pkg::POS_W-1:0];
		it.radius = r[ctg_pkg::RAD_W-1:0];
		return it;
	endfunction

	function automatic grid_item_t random_item();
		grid_item_t it;
		longint ts, w, h, x, z, r, r_lim, span;
		logic signed [ctg_pkg::POS_W-1:0] sx, sz;
		logic [31:0] rnd;
		int pick, col_lim, row_lim;
		ts = longint'(tile_size_q);
		w = longint'(map_cols_q) * ts;
		h = longint'(map_rows_q) * ts;
		col_lim = (map_cols_q == 0 || map_cols_q > GRID_COLS) ? GRID_COLS - 1
			: int'(map_cols_q) - 1;
		row_lim = (map_rows_q == 0 || map_rows_q > GRID_ROWS) ? GRID_ROWS - 1
			: int'(map_rows_q) - 1;
		it = '{default: '0};
		pick = int'($urandom_range(99));
		if (pick < 45) begin
			it.action = ctg_pkg::ACT_WRITE;
			rnd = $urandom;
			it.pos_x = rnd[ctg_pkg::POS_W-1:0];
			rnd = $urandom;
			it.pos_z = rnd[ctg_pkg::POS_W-1:0];
			rnd = $urandom;
			it.radius = rnd[ctg_pkg::RAD_W-1:0];
			if (pick < 35) begin
				rnd = $urandom_range(col_lim);
				it.tile_col = rnd[5:0];
				rnd = $urandom_range(row_lim);
				it.tile_row = rnd[5:0];
				case ($urandom_range(2))
					0: it.tile_code = ctg_pkg::CODE_WALL;
					1: it.tile_code = ctg_pkg::CODE_GREEN;
					default: begin
						rnd = $urandom;
						it.tile_code = rnd[7:0];
					end
				endcase
			end else begin
				rnd = $urandom;
				it.tile_col = rnd[5:0];
				it.tile_row = rnd[11:6];
				it.tile_code = rnd[19:12];
			end
			return it;
		end
		it.action = ctg_pkg::ACT_QUERY;
		rnd = $urandom;
		it.tile_col = rnd[5:0];
		it.tile_row = rnd[11:6];
		it.tile_code = rnd[19:12];
		if (pick < 90) begin
			r_lim = (2 * ts + 2 > 65535) ? 65535 : 2 * ts + 2;
			r = longint'($urandom_range(r_lim[31:0]));
			if (pick < 68) begin
				span = 3 * ts;
				x = last_col * ts + longint'($urandom_range(span[31:0])) - ts;
				z = last_row * ts + longint'($urandom_range(span[31:0])) - ts;
			end else begin
				x = longint'($urandom_range(w[31:0]));
				z = longint'($urandom_range(h[31:0]));
			end
		end else begin
			rnd = $urandom;
			sx = rnd[ctg_pkg::POS_W-1:0];
			rnd = $urandom;
			sz = rnd[ctg_pkg::POS_W-1:0];
			x = longint'(sx);
			z = longint'(sz);
			r = longint'($urandom_range(65535));
		end
		// keep the tile walk of a query that passes the map edge test short
		while (ts != 0 && r > 0 && x - r >= 0 && x + r <= w && z - r >= 0 && z + r <= h &&
			((x + r) / ts - (x - r) / ts + 1) * ((z + r) / ts - (z - r) / ts + 1) > 400)
			r = r / 2;
		it.pos_x = x[ctg_pkg::POS_W-1:0];
		it.pos_z = z[ctg_pkg::POS_W-1:0];
		it.radius = r[ctg_pkg::RAD_W-1:0];
		return it;
	endfunction

	task automatic send_item(input grid_item_t it);
		@(negedge clk);
		while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		action <= it.action;
		tile_col <= it.tile_col;
		tile_row <= it.tile_row;
		tile_code <= it.tile_code;
		pos_x <= it.pos_x;
		pos_z <= it.pos_z;
		radius <= it.radius;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (it.action == ctg_pkg::ACT_WRITE) begin
			solid_tiles[it.tile_row][it.tile_col] =
				(it.tile_code == ctg_pkg::CODE_WALL || it.tile_code == ctg_pkg::CODE_GREEN);
			last_col = int'(it.tile_col);
			last_row = int'(it.tile_row);
			n_tile_writes++;
		end else begin
			pending_results.push_back(collision_for(it.pos_x, it.pos_z, it.radius));
			n_queries++;
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ctg_pkg::CFG_W-1:0] idx,
		input logic [ctg_pkg::DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			ctg_pkg::CFG_TILE_SIZE:   tile_size_q = data[ctg_pkg::TS_W-1:0];
			ctg_pkg::CFG_MAP_COLUMNS: map_cols_q = data[ctg_pkg::IDX_W-1:0];
			ctg_pkg::CFG_MAP_ROWS:    map_rows_q = data[ctg_pkg::IDX_W-1:0];
			default: ;
		endcase
		n_reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_map(input int ts, input int cols, input int rows);
		write_reg(ctg_pkg::CFG_TILE_SIZE, ts[ctg_pkg::DATA_W-1:0]);
		write_reg(ctg_pkg::CFG_MAP_COLUMNS, cols[ctg_pkg::DATA_W-1:0]);
		write_reg(ctg_pkg::CFG_MAP_ROWS, rows[ctg_pkg::DATA_W-1:0]);
		n_settings++;
	endtask

	task automatic send_random(input int count);
		repeat (count) send_item(random_item());
	endtask

	// reset register values, edge cases of distance, map edge and field extremes
	task automatic test_directed_defaults();
		send_item(tile_item(0, 0, ctg_pkg::CODE_WALL));
		send_item(tile_item(63, 63, ctg_pkg::CODE_GREEN));
		send_item(tile_item(1, 0, 8'h41));
		send_item(tile_item(5, 5, ctg_pkg::CODE_WALL));
		send_item(tile_item(5, 5, 8'h20));
		send_item(query_item(128, 128, 64));
		send_item(query_item(128, 128, 0));
		send_item(query_item(356, 128, 101));
		send_item(query_item(357, 128, 101));
		send_item(query_item(300, 300, 60));
		send_item(query_item(300, 300, 63));
		send_item(query_item(1408, 1408, 128));
		send_item(query_item(16256, 16256, 128));
		send_item(query_item(16257, 8000, 128));
		send_item(query_item(127, 8000, 128));
		send_item(query_item(8000, 0, 1));
		send_item(query_item(8000, 16384, 1));
		send_item(query_item(24'h7FFFFF, 100, 0));
		send_item(query_item(-8388608, 100, 0));
		send_item(query_item(100, -8388608, 0));
		send_item(query_item(8192, 8192, 65535));
		send_item(query_item(8192, 8192, 300));
		send_item(query_item(0, 0, 0));
		wait_idle();
	endtask

	// zero tile size leaves only the map edge test
	task automatic test_zero_tile_size();
		set_map(0, 64, 64);
		send_item(query_item(0, 0, 0));
		send_item(query_item(0, 0, 1));
		send_item(query_item(1, 0, 0));
		send_item(tile_item(2, 2, ctg_pkg::CODE_WALL));
		send_item(query_item(0, 1, 0));
		wait_idle();
		write_reg(CFG_SPARE, 16'hFFFF);
	endtask

	// register extremes, columns beyond the store and wide index values
	task automatic test_register_extremes();
		int settings [7][3];
		settings = '{'{1, 64, 64}, '{65535, 1, 1}, '{65535, 64, 64}, '{256, 1, 64},
			'{256, 64, 1}, '{300, 100, 64}, '{7, 127, 127}};
		foreach (settings[i]) begin
			set_map(settings[i][0], settings[i][1], settings[i][2]);
			send_random(50);
			wait_idle();
		end
	endtask

	// wide queries; the bounding box of the first one spans the whole map
	task automatic test_wide_circles();
		set_map(256, 64, 64);
		send_item(query_item(8192, 8192, 8192));
		send_item(query_item(8000, 8300, 7900));
		send_item(query_item(4096, 12000, 4000));
		wait_idle();
	endtask

	// result side held off while items keep coming
	task automatic test_result_backpressure();
		set_map(64, 8, 8);
		hold_request = HOLD_CYCLES;
		steady_flow = 1'b1;
		send_random(40);
		steady_flow = 1'b0;
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int ts, cols, rows;
		for (int phase = 0; phase < 10; phase++) begin
			ts = ($urandom_range(9) == 0) ? int'($urandom_range(65535, 1))
				: int'($urandom_range(1024, 1));
			cols = $urandom_range(1) ? int'($urandom_range(8, 1)) : int'($urandom_range(64, 1));
			rows = $urandom_range(1) ? int'($urandom_range(8, 1)) : int'($urandom_range(64, 1));
			set_map(ts, cols, rows);
			steady_flow = (phase == 3 || phase == 4);
			send_random(100);
			steady_flow = 1'b0;
			wait_idle();
		end
	endtask

	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (collided && hit_boundary)
				n_boundary_hits++;
			else if (collided)
				n_tile_hits++;
			else
				n_misses++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result collided=%0b hit_boundary=%0b",
					$time, collided, hit_boundary);
			end else begin
				want = pending_results.pop_front();
				if (collided !== want.collided) begin
					errors++;
					$display("%0t: collided expected %0b actual %0b", $time,
						want.collided, collided);
				end
				if (hit_boundary !== want.hit_boundary) begin
					errors++;
					$display("%0t: hit_boundary expected %0b actual %0b", $time,
						want.hit_boundary, hit_boundary);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_defaults();
		test_zero_tile_size();
		test_register_extremes();
		test_wide_circles();
		test_result_backpressure();
		test_random_traffic();
		wait_idle();
		if (pending_results.size() != 0) begin
			errors += pending_results.size();
			$display("%0t: %0d results never arrived", $time, pending_results.size());
		end
		$display("covered %0d tile writes and %0d queries over %0d map settings",
			n_tile_writes, n_queries, n_settings);
		$display("(%0d reg writes); results: %0d edge hits, %0d tile hits, %0d misses",
			n_reg_writes, n_boundary_hits, n_tile_hits, n_misses);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ circle_tile_grid_collision_core.f @@
+incdir+sv
sv/ctg_pkg.sv
sv/circle_tile_grid_collision_core.sv
verif/circle_tile_grid_collision_core_tb.sv
